// ----- rtl/string_literal_escape_decoder_defines.svh -----
// assertion macros for the string literal escape decoder
`ifndef STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH
`define STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked at every rising edge outside reset
`define SLED_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sled assertion failed");
// next-cycle implication
`define SLED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sled assertion failed");
`else
`define SLED_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SLED_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/sled_pkg.sv -----
// shared types, codes and helpers of the string literal escape decoder
package sled_pkg;

  // decoder mode of the front end
  typedef enum logic [2:0] {
    MODE_TEXT = 3'd0,
    MODE_BSL  = 3'd1,
    MODE_HEX  = 3'd2,
    MODE_OCT  = 3'd3,
    MODE_UCN  = 3'd4
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNTERM     = 3'd1,
    ST_NO_HEX     = 3'd2,
    ST_HEX_RANGE  = 3'd3,
    ST_OCT_RANGE  = 3'd4,
    ST_SHORT_UCN  = 3'd5,
    ST_UCN_NONHEX = 3'd6,
    ST_BAD_CP     = 3'd7
  } status_t;

  // prefix kinds
  localparam logic [1:0] PFX_BYTE  = 2'd0;
  localparam logic [1:0] PFX_WIDE16 = 2'd1;

  // code point limits
  localparam logic [31:0] SURR_LO = 32'h0000_D800;
  localparam logic [31:0] SURR_HI = 32'h0000_DFFF;
  localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;

  // utf-8 lead and continuation marks
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // results of one input item: up to four bytes, the last one an error when st is not ok
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
    status_t         st;
    logic            eol;
  } group_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // value beyond the escape limit of the prefix kind
  function automatic logic over_limit(input logic [31:0] v, input logic [1:0] kind);
    logic r;
    case (kind)
      PFX_BYTE:   r = |v[31:8];
      PFX_WIDE16: r = |v[31:16];
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/sled_front.sv -----
// front end: accepts body bytes, runs the escape state machine, builds result groups
module sled_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        prefix_kind,
  input  logic              s_tvalid,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  output logic              s_tready,
  input  logic              q_full,
  output logic              push,
  output sled_pkg::group_t  grp
);

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_U_LO = 8'h75;
  localparam logic [7:0] CH_U_UP = 8'h55;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_V   = 8'h76;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_7   = 8'h37;

  sled_pkg::mode_t mode, mode_next;
  logic [31:0] acc, acc_next;
  logic        ovf, ovf_next;
  logic [3:0]  dcnt, dcnt_next;
  logic        long_ucn, long_ucn_next;
  logic        skip, skip_next;

  logic        accept;
  logic [7:0]  c;
  logic        last;
  logic [4:0]  hx;
  logic        is_oct;
  logic        is_bsl;
  logic [31:0] hex_acc, oct_acc, ucn_acc;
  logic        hex_ovf, ucn_ovf;
  logic [3:0]  hex_cnt, oct_cnt, ucn_cnt;
  logic        ucn_done, ucn_bad;
  logic        hfin_ok, ofin_ok;
  sled_pkg::status_t err;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign c        = s_tdata;
  assign last     = s_tlast;

  // digit paths
  assign hx      = sled_pkg::hex_digit(c);
  assign is_oct  = (c >= CH_0) && (c <= CH_7);
  assign is_bsl  = (c == CH_BSL);
  assign hex_acc = {acc[27:0], hx[3:0]};
  assign hex_ovf = ovf || (acc[31:28] != 4'd0);
  assign hex_cnt = (dcnt == 4'd15) ? dcnt : dcnt + 4'd1;
  assign oct_acc = {acc[28:0], c[2:0]};
  assign oct_cnt = dcnt + 4'd1;
  assign ucn_acc = hx[4] ? {acc[27:0], hx[3:0]} : acc;
  assign ucn_ovf = ovf || !hx[4];
  assign ucn_cnt = dcnt + 4'd1;
  assign ucn_done = long_ucn ? (ucn_cnt >= 4'd8) : (ucn_cnt >= 4'd4);
  assign ucn_bad = ((ucn_acc >= sled_pkg::SURR_LO) && (ucn_acc <= sled_pkg::SURR_HI)) ||
                   (ucn_acc > sled_pkg::CP_MAX);
  // closing an escape on the current value, before this byte
  assign hfin_ok = (dcnt != 4'd0) && !ovf && !sled_pkg::over_limit(acc, prefix_kind);
  assign ofin_ok = !sled_pkg::over_limit(acc, prefix_kind);

  // error classification
  always_comb begin
    err = sled_pkg::ST_OK;
    if (!skip) begin
      case (mode)
        sled_pkg::MODE_BSL: begin
          if (last && (c == CH_U_LO || c == CH_U_UP)) begin
            err = sled_pkg::ST_SHORT_UCN;
          end else if (last && c == CH_X) begin
            err = sled_pkg::ST_NO_HEX;
          end
        end
        sled_pkg::MODE_HEX: begin
          if (hx[4]) begin
            if (last && (hex_ovf || sled_pkg::over_limit(hex_acc, prefix_kind))) begin
              err = sled_pkg::ST_HEX_RANGE;
            end
          end else if (dcnt == 4'd0) begin
            err = sled_pkg::ST_NO_HEX;
          end else if (!hfin_ok) begin
            err = sled_pkg::ST_HEX_RANGE;
          end else if (is_bsl && last) begin
            err = sled_pkg::ST_UNTERM;
          end
        end
        sled_pkg::MODE_OCT: begin
          if (is_oct) begin
            if ((oct_cnt >= 4'd3 || last) &&
                sled_pkg::over_limit(oct_acc, prefix_kind)) begin
              err = sled_pkg::ST_OCT_RANGE;
            end
          end else if (!ofin_ok) begin
            err = sled_pkg::ST_OCT_RANGE;
          end else if (is_bsl && last) begin
            err = sled_pkg::ST_UNTERM;
          end
        end
        sled_pkg::MODE_UCN: begin
          if (ucn_done) begin
            if (ucn_ovf) begin
              err = sled_pkg::ST_UCN_NONHEX;
            end else if (ucn_bad) begin
              err = sled_pkg::ST_BAD_CP;
            end
          end else if (last) begin
            err = sled_pkg::ST_SHORT_UCN;
          end
        end
        default: begin
          if (is_bsl && last) begin
            err = sled_pkg::ST_UNTERM;
          end
        end
      endcase
    end
  end

  // next state
  always_comb begin
    mode_next     = mode;
    acc_next      = acc;
    ovf_next      = ovf;
    dcnt_next     = dcnt;
    long_ucn_next = long_ucn;
    skip_next     = skip;
    if (skip) begin
      skip_next = skip;
    end else if (err != sled_pkg::ST_OK) begin
      mode_next     = sled_pkg::MODE_TEXT;
      acc_next      = '0;
      ovf_next      = 1'b0;
      dcnt_next     = 4'd0;
      long_ucn_next = 1'b0;
      skip_next     = !last;
    end else begin
      case (mode)
        sled_pkg::MODE_BSL: begin
          mode_next = sled_pkg::MODE_TEXT;
          acc_next  = '0;
          ovf_next  = 1'b0;
          dcnt_next = 4'd0;
          if (c == CH_U_LO || c == CH_U_UP) begin
            mode_next     = sled_pkg::MODE_UCN;
            long_ucn_next = (c == CH_U_UP);
          end else if (c == CH_X) begin
            mode_next = sled_pkg::MODE_HEX;
          end else if (is_oct) begin
            mode_next = sled_pkg::MODE_OCT;
            acc_next  = {29'd0, c[2:0]};
            dcnt_next = 4'd1;
          end
        end
        sled_pkg::MODE_HEX: begin
          if (hx[4]) begin
            acc_next  = hex_acc;
            ovf_next  = hex_ovf;
            dcnt_next = hex_cnt;
          end else begin
            mode_next = is_bsl ? sled_pkg::MODE_BSL : sled_pkg::MODE_TEXT;
          end
        end
        sled_pkg::MODE_OCT: begin
          if (is_oct) begin
            acc_next  = oct_acc;
            dcnt_next = oct_cnt;
            if (oct_cnt >= 4'd3) begin
              mode_next = sled_pkg::MODE_TEXT;
            end
          end else begin
            mode_next = is_bsl ? sled_pkg::MODE_BSL : sled_pkg::MODE_TEXT;
          end
        end
        sled_pkg::MODE_UCN: begin
          acc_next  = ucn_acc;
          ovf_next  = ucn_ovf;
          dcnt_next = ucn_cnt;
          if (ucn_done) begin
            mode_next = sled_pkg::MODE_TEXT;
          end
        end
        default: begin
          mode_next = is_bsl ? sled_pkg::MODE_BSL : sled_pkg::MODE_TEXT;
        end
      endcase
    end
    // end of literal: start the next one clean
    if (last) begin
      mode_next     = sled_pkg::MODE_TEXT;
      acc_next      = '0;
      ovf_next      = 1'b0;
      dcnt_next     = 4'd0;
      long_ucn_next = 1'b0;
      skip_next     = 1'b0;
    end
  end

  // result group
  always_comb begin
    logic [2:0]  k;
    logic [7:0]  m;
    logic [31:0] cp;
    k  = 3'd0;
    m  = c;
    cp = ucn_acc;
    grp.bytes = '0;
    if (!skip) begin
      case (mode)
        sled_pkg::MODE_BSL: begin
          case (c)
            CH_A:    m = 8'h07;
            CH_B:    m = 8'h08;
            CH_F:    m = 8'h0C;
            CH_N:    m = 8'h0A;
            CH_R:    m = 8'h0D;
            CH_T:    m = 8'h09;
            CH_V:    m = 8'h0B;
            default: m = c;
          endcase
          if (is_oct) begin
            if (last) begin
              grp.bytes[k[1:0]] = {5'd0, c[2:0]};
              k = k + 3'd1;
            end
          end else if (c != CH_U_LO && c != CH_U_UP && c != CH_X) begin
            grp.bytes[k[1:0]] = m;
            k = k + 3'd1;
          end
        end
        sled_pkg::MODE_HEX: begin
          if (hx[4]) begin
            if (last && err == sled_pkg::ST_OK) begin
              grp.bytes[k[1:0]] = hex_acc[7:0];
              k = k + 3'd1;
            end
          end else if (hfin_ok) begin
            grp.bytes[k[1:0]] = acc[7:0];
            k = k + 3'd1;
            if (!is_bsl) begin
              grp.bytes[k[1:0]] = c;
              k = k + 3'd1;
            end
          end
        end
        sled_pkg::MODE_OCT: begin
          if (is_oct) begin
            if ((oct_cnt >= 4'd3 || last) && err == sled_pkg::ST_OK) begin
              grp.bytes[k[1:0]] = oct_acc[7:0];
              k = k + 3'd1;
            end
          end else if (ofin_ok) begin
            grp.bytes[k[1:0]] = acc[7:0];
            k = k + 3'd1;
            if (!is_bsl) begin
              grp.bytes[k[1:0]] = c;
              k = k + 3'd1;
            end
          end
        end
        sled_pkg::MODE_UCN: begin
          if (ucn_done && err == sled_pkg::ST_OK) begin
            if (cp < 32'h80) begin
              grp.bytes[0] = cp[7:0];
              k = 3'd1;
            end else if (cp < 32'h800) begin
              grp.bytes[0] = sled_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]};
              grp.bytes[1] = sled_pkg::UTF8_CONT | {2'd0, cp[5:0]};
              k = 3'd2;
            end else if (cp < 32'h10000) begin
              grp.bytes[0] = sled_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]};
              grp.bytes[1] = sled_pkg::UTF8_CONT | {2'd0, cp[11:6]};
              grp.bytes[2] = sled_pkg::UTF8_CONT | {2'd0, cp[5:0]};
              k = 3'd3;
            end else begin
              grp.bytes[0] = sled_pkg::UTF8_LEAD4 | {5'd0, cp[20:18]};
              grp.bytes[1] = sled_pkg::UTF8_CONT | {2'd0, cp[17:12]};
              grp.bytes[2] = sled_pkg::UTF8_CONT | {2'd0, cp[11:6]};
              grp.bytes[3] = sled_pkg::UTF8_CONT | {2'd0, cp[5:0]};
              k = 3'd4;
            end
          end
        end
        default: begin
          if (!is_bsl) begin
            grp.bytes[k[1:0]] = c;
            k = k + 3'd1;
          end
        end
      endcase
      // error entry always closes the group
      if (err != sled_pkg::ST_OK) begin
        k = k + 3'd1;
      end
    end
    grp.cnt = k;
    grp.st  = err;
    grp.eol = last || (err != sled_pkg::ST_OK);
  end

  assign push = accept && (grp.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= sled_pkg::MODE_TEXT;
      acc      <= '0;
      ovf      <= 1'b0;
      dcnt     <= 4'd0;
      long_ucn <= 1'b0;
      skip     <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      acc      <= acc_next;
      ovf      <= ovf_next;
      dcnt     <= dcnt_next;
      long_ucn <= long_ucn_next;
      skip     <= skip_next;
    end
  end

endmodule

// ----- rtl/sled_queue.sv -----
// short queue of result groups between front and back
module sled_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sled_pkg::group_t  push_data,
  input  logic              pop,
  output logic              full,
  output logic              valid,
  output sled_pkg::group_t  data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sled_pkg::group_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/sled_back.sv -----
// back end: holds one result group and sends it out one beat per cycle while m_tready is high
module sled_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sled_pkg::group_t  q_data,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic [3:0]        m_tuser
);

  sled_pkg::group_t grp;
  logic             busy;
  logic [1:0]       idx;
  logic             last_beat;
  logic             err_beat;

  assign last_beat = busy && (({1'b0, idx} + 3'd1) == grp.cnt);
  assign err_beat  = last_beat && (grp.st != sled_pkg::ST_OK);
  assign pop       = q_valid && (!busy || (m_tready && last_beat));

  assign m_tvalid = busy;
  assign m_tdata  = err_beat ? 8'd0 : grp.bytes[idx];
  assign m_tlast  = last_beat && grp.eol;
  assign m_tuser  = {(last_beat ? grp.st : sled_pkg::ST_OK), !err_beat};

  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && m_tready) begin
      if (last_beat) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ----- rtl/string_literal_escape_decoder.sv -----
// top level of the string literal escape decoder
// decodes the body bytes of a string literal, one byte per input beat with tlast on the
// final byte, into output bytes: plain bytes pass through, simple escapes become their
// control codes, hex and octal escapes are range-checked against prefix_kind (0: 8 bit,
// 1: 16 bit, 2 or 3: 32 bit) and truncated to a byte, and \u / \U names are checked and
// sent as one to four utf-8 bytes. an error gives one beat with byte_valid low, tlast high
// and a nonzero status, and the rest of that literal is swallowed up to its tlast. the
// front end takes one input beat every cycle as long as the result queue (QUEUE_DEPTH
// groups) has room; the back end sends one output beat per cycle while m_tready is high,
// so a result occupies the output for one beat per byte, and the output side sets the
// sustained rate when many multi-byte results come in a row. when nothing is queued an
// accepted input beat is written into the queue, then into the back end's group register,
// which offers its first output beat. write prefix_kind only while the block is idle
module string_literal_escape_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // configuration: prefix kind
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_byte
  input  logic       s_tlast,   // last_char
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // end_of_literal
  output logic [3:0] m_tuser    // [0] byte_valid, [3:1] status
);

  logic [1:0]       prefix_kind;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  sled_pkg::group_t front_grp;
  sled_pkg::group_t q_data;

  // escape limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_kind <= sled_pkg::PFX_BYTE;
    end else if (cfg_we) begin
      prefix_kind <= cfg_data;
    end
  end

  // classification and escape state machine, one byte per cycle while the queue has room
  sled_front u_front (
    .clk         (clk),
    .rst         (rst),
    .prefix_kind (prefix_kind),
    .s_tvalid    (s_tvalid),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .s_tready    (s_tready),
    .q_full      (q_full),
    .push        (q_push),
    .grp         (front_grp)
  );

  // decouples byte intake from multi-beat output bursts
  sled_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_grp),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .data      (q_data)
  );

  // group serialiser, one beat per cycle while m_tready is high
  sled_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`include "string_literal_escape_decoder_defines.svh"

  // an error beat carries no byte and closes the literal
  `SLED_ASSERT_IMP(a_err_beat_closes, clk, rst, m_tvalid && (m_tuser[3:1] != sled_pkg::ST_OK), m_tlast && !m_tuser[0])
  // a beat without a byte is always an error beat
  `SLED_ASSERT_IMP(a_novalid_is_err, clk, rst, m_tvalid && !m_tuser[0], m_tuser[3:1] != sled_pkg::ST_OK)
  // the front never writes into a full queue
  `SLED_ASSERT_IMP(a_no_push_full, clk, rst, q_push, !q_full)
  // a full queue with nothing leaving keeps the input stalled
  `SLED_ASSERT_NEXT(a_full_holds, clk, rst, q_full && !q_pop, !s_tready)

endmodule
